// File: rtl/core/kuf_pkg.sv
// Shared types and fixed field widths for the Kruskal union-find block.
package kuf_pkg;

	localparam int NODE_W   = 10;
	localparam int WEIGHT_W = 16;
	localparam int TOTAL_W  = 32;
	localparam int COUNT_W  = 11;

	typedef logic [NODE_W-1:0]   node_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [TOTAL_W-1:0]  total_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam count_t COUNT_RESET = 11'd1024;
	localparam total_t TOTAL_MAX   = '1;

endpackage

// File: rtl/core/kruskal_union_find_mst.sv
// Top level: Kruskal spanning-tree accumulator over a disjoint-set forest held in RAM.
//
// Edges must arrive in ascending weight order (the block does not check this),
// one item per edge, and each item yields one result: whether the edge joined
// two trees, the saturating running tree weight, an out-of-range flag and a
// copy of the last-edge mark. The parent and tree-size tables each sit in a
// single-port-read RAM with a registered read, and one sequencer walks them: per
// endpoint a walk up the parent chain to its root, then a path-compression walk
// that repoints each path entry straight at the root, then a read of both root
// sizes and a union by size (skipped when both ends already share a root; an
// out-of-range edge goes straight to the result). Every parent read waits for
// the previous one, so the chain length sets the rate. After reset, and when an
// item carries first_edge, a clearing pass rewrites all MAX_NODES entries, one a
// cycle, and the item waits behind it; cfg writes to node_count are taken at any time.
module kruskal_union_find_mst #(
	parameter int MAX_NODES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	// node count register
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  kuf_pkg::count_t node_count,
	// edge items
	input  logic            in_valid,
	output logic            in_stall,
	input  kuf_pkg::node_t  from_node,
	input  kuf_pkg::node_t  to_node,
	input  kuf_pkg::weight_t edge_weight,
	input  logic            first_edge,
	input  logic            last_edge,
	// result items
	output logic            out_valid,
	input  logic            out_stall,
	output logic            joined,
	output kuf_pkg::total_t tree_weight,
	output logic            bad_node,
	output logic            done_res
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);

	typedef logic [AW-1:0] addr_t;
	typedef logic [SW-1:0] size_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_ROOT,
		ST_PATH,
		ST_SIZE,
		ST_UNION,
		ST_FINISH
	} state_t;

	state_t           state_q;
	addr_t            clr_q;
	logic             pending_q;
	kuf_pkg::count_t  ncount_q;
	kuf_pkg::node_t   u_q;
	kuf_pkg::node_t   v_q;
	kuf_pkg::weight_t w_q;
	logic             last_q;
	logic             second_q;
	addr_t            root_q;
	addr_t            start_q;
	addr_t            cur_q;
	addr_t            ru_q;
	addr_t            rv_q;
	size_t            su_q;
	kuf_pkg::total_t  total_q;
	logic             bad_q;
	logic             joined_q;
	logic             out_valid_q;
	logic             out_joined_q;
	kuf_pkg::total_t  out_weight_q;
	logic             out_bad_q;
	logic             out_done_q;

	// RAM ports
	logic  par_we;
	addr_t par_waddr;
	addr_t par_wdata;
	addr_t par_raddr;
	addr_t par_rdata;
	logic  sz_we;
	addr_t sz_waddr;
	size_t sz_wdata;
	addr_t sz_raddr;
	size_t sz_rdata;

	logic  in_acc;
	logic  edge_bad;
	logic  find_done;
	logic  out_free;
	size_t sz_sum;
	logic  [kuf_pkg::TOTAL_W:0] sum_ext;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// An endpoint must sit below both the programmed count and the table depth.
	assign edge_bad = ({1'b0, u_q} >= ncount_q) || ({1'b0, v_q} >= ncount_q) ||
			(32'(u_q) >= 32'(MAX_NODES)) || (32'(v_q) >= 32'(MAX_NODES));

	// A find ends when the root walk hits a root that is its own start node, or
	// when the compression walk reaches the root.
	assign find_done = ((state_q == ST_ROOT) && (par_rdata == root_q) && (start_q == root_q)) ||
			((state_q == ST_PATH) && (par_rdata == root_q));

	assign sz_sum  = su_q + sz_rdata;
	assign sum_ext = {1'b0, total_q} + (kuf_pkg::TOTAL_W + 1)'(w_q);

	// Memory request steering: reads are issued from the data just returned.
	always_comb begin
		par_we    = 1'b0;
		par_waddr = clr_q;
		par_wdata = clr_q;
		par_raddr = root_q;
		sz_we     = 1'b0;
		sz_waddr  = clr_q;
		sz_wdata  = size_t'(1);
		sz_raddr  = ru_q;
		case (state_q)
			ST_CLEAR: begin
				par_we = 1'b1;
				sz_we  = 1'b1;
			end
			ST_START: begin
				par_raddr = AW'(u_q);
			end
			ST_ROOT: begin
				if (par_rdata != root_q) begin
					par_raddr = par_rdata;
				end else begin
					par_raddr = start_q;
				end
			end
			ST_PATH: begin
				// repoint this path entry straight at the root
				par_we    = 1'b1;
				par_waddr = cur_q;
				par_wdata = root_q;
				par_raddr = par_rdata;
			end
			ST_SIZE: begin
				sz_raddr = rv_q;
			end
			ST_UNION: begin
				par_we = 1'b1;
				sz_we  = 1'b1;
				sz_wdata = sz_sum;
				if (su_q < sz_rdata) begin
					par_waddr = ru_q;
					par_wdata = rv_q;
					sz_waddr  = rv_q;
				end else begin
					par_waddr = rv_q;
					par_wdata = ru_q;
					sz_waddr  = ru_q;
				end
			end
			default: begin
			end
		endcase
		// End of a find: launch the second find or the size reads.
		if (find_done) begin
			if (!second_q) begin
				par_raddr = AW'(v_q);
			end else begin
				sz_raddr = ru_q;
			end
		end
	end

	kuf_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_parent_ram (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.raddr (par_raddr),
		.rdata (par_rdata)
	);

	kuf_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_size_ram (
		.clk   (clk),
		.we    (sz_we),
		.waddr (sz_waddr),
		.wdata (sz_wdata),
		.raddr (sz_raddr),
		.rdata (sz_rdata)
	);

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pending_q   <= 1'b0;
			ncount_q    <= kuf_pkg::COUNT_RESET;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ncount_q <= node_count;
			end
			// drop the result once the consumer takes it; the finishing step
			// refills the register itself
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(MAX_NODES - 1)) begin
						clr_q     <= '0;
						pending_q <= 1'b0;
						state_q   <= pending_q ? ST_START : ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						u_q    <= from_node;
						v_q    <= to_node;
						w_q    <= edge_weight;
						last_q <= last_edge;
						if (first_edge) begin
							// reinitialize the forest before handling this item
							total_q   <= '0;
							pending_q <= 1'b1;
							clr_q     <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					bad_q    <= edge_bad;
					joined_q <= 1'b0;
					second_q <= 1'b0;
					root_q   <= AW'(u_q);
					start_q  <= AW'(u_q);
					state_q  <= edge_bad ? ST_FINISH : ST_ROOT;
				end
				ST_ROOT: begin
					if (par_rdata != root_q) begin
						// advance toward the root
						root_q <= par_rdata;
					end else if (start_q != root_q) begin
						cur_q   <= start_q;
						state_q <= ST_PATH;
					end
				end
				ST_PATH: begin
					if (par_rdata != root_q) begin
						cur_q <= par_rdata;
					end
				end
				ST_SIZE: begin
					su_q    <= sz_rdata;
					state_q <= ST_UNION;
				end
				ST_UNION: begin
					total_q  <= sum_ext[kuf_pkg::TOTAL_W] ? kuf_pkg::TOTAL_MAX
							: sum_ext[kuf_pkg::TOTAL_W-1:0];
					joined_q <= 1'b1;
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_joined_q <= joined_q;
						out_weight_q <= total_q;
						out_bad_q    <= bad_q;
						out_done_q   <= last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (find_done) begin
				if (!second_q) begin
					ru_q     <= root_q;
					second_q <= 1'b1;
					root_q   <= AW'(v_q);
					start_q  <= AW'(v_q);
					state_q  <= ST_ROOT;
				end else begin
					rv_q    <= root_q;
					state_q <= (ru_q == root_q) ? ST_FINISH : ST_SIZE;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign joined      = out_joined_q;
	assign tree_weight = out_weight_q;
	assign bad_node    = out_bad_q;
	assign done_res    = out_done_q;

	// A result appears only out of the finishing step.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish step");

	// An edge is never both taken and flagged out of range.
	a_joined_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_joined_q && out_bad_q))
		else $error("joined and bad_node both set");

	// A union always links two distinct roots.
	a_union_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNION) |-> (ru_q != rv_q))
		else $error("union of a tree with itself");

	// A first-edge item clears the running weight and starts a clearing pass.
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && first_edge) |=> (total_q == '0) && (state_q == ST_CLEAR) && pending_q)
		else $error("first edge did not reinitialize");

endmodule

// File: rtl/core/kuf_ram.sv
// Generic simple dual-port RAM with registered read and write-through on collision.
module kuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule
